// ===== hdl/differential_drive_odometry_macros.svh =====
// assertion macros for the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// next-cycle implication, switched off while reset is held
`define DDO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("odometry check failed");

// next-cycle implication that also holds across reset
`define DDO_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("odometry check failed");

`endif

// ===== hdl/ddo_pkg.sv =====
// types and constants shared by the odometry modules
`default_nettype none
package ddo_pkg;

    typedef struct packed {
        logic               op;
        logic signed [15:0] left_travel;
        logic signed [15:0] right_travel;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic               held;
    } t_out_word;

    localparam int ATAN_ENTRIES = 24;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] INV_PI_Q32  = 34'sd1367130551;

    localparam int DIV_BITS  = 50;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    // ceil(2^32 / 25), exact for the quotients seen here
    localparam logic [27:0] RECIP_25 = 28'd171798692;
    localparam logic [55:0] HALF_25  = 56'd13421772800;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR,
        DP_MULN,
        DP_DIVINIT,
        DP_DIVSTEP,
        DP_ANGLE,
        DP_ROT,
        DP_MULC,
        DP_MULS,
        DP_ROUND,
        DP_RECIP,
        DP_ADDX,
        DP_ADDY,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        logic is_clear;
        logic axle_zero;
        logic div_last;
        logic rot_last;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hdl/ddo_dpath.sv =====
// odometry datapath: divider, cordic, shared multiplier and pose registers
`default_nettype none
module ddo_dpath #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ddo_pkg::t_dp_op    i_op,
    input  ddo_pkg::t_in_word  i_in_data,
    input  wire                i_cfg_valid,
    input  wire         [15:0] i_cfg_data,
    output ddo_pkg::t_dp_sts   o_sts,
    output ddo_pkg::t_out_word o_out_data
);
    import ddo_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    logic        [15:0]          r_axle;
    logic signed [31:0]          r_px;
    logic signed [31:0]          r_py;
    logic        [15:0]          r_yaw;
    logic                        r_is_clear;
    logic                        r_held;
    logic signed [16:0]          r_sum;
    logic signed [16:0]          r_diff;
    logic signed [50:0]          r_prod;
    logic                        r_neg;
    logic        [49:0]          r_num;
    logic        [15:0]          r_rem;
    logic        [33:0]          r_quo;
    logic        [DIV_CNT_W-1:0] r_dcnt;
    logic        [33:0]          r_d34;
    logic        [1:0]           r_quad;
    logic signed [33:0]          r_x;
    logic signed [33:0]          r_y;
    logic signed [33:0]          r_z;
    logic        [STEP_W-1:0]    r_i;
    logic        [23:0]          r_t;
    logic        [19:0]          r_q;
    t_out_word                   r_out;

    logic signed [16:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [50:0] mul_p;
    logic        [50:0] prod_mag;
    logic        [16:0] rem_sh;
    logic               rem_ge;
    logic        [16:0] rem_nx;
    logic        [33:0] d34;
    logic        [33:0] mid34;
    logic        [31:0] ang;
    logic        [31:0] ang_q;
    logic        [1:0]  quad;
    logic        [31:0] resid;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] atan_v;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
    logic        [55:0] rnd;
    logic        [51:0] rq;
    logic        [31:0] delta;
    logic        [33:0] yaw_sum;

    always_comb begin
        cos_v = r_x;
        sin_v = r_y;
        case (r_quad)
            2'd0: begin cos_v = r_x;  sin_v = r_y;  end
            2'd1: begin cos_v = -r_y; sin_v = r_x;  end
            2'd2: begin cos_v = -r_x; sin_v = -r_y; end
            default: begin cos_v = r_y; sin_v = -r_x; end
        endcase
    end

    always_comb begin
        mul_a = r_sum;
        mul_b = cos_v;
        case (i_op)
            DP_MULN: begin mul_a = r_diff; mul_b = INV_PI_Q32; end
            DP_MULS: begin mul_a = r_sum;  mul_b = sin_v;      end
            default: begin mul_a = r_sum;  mul_b = cos_v;      end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_mag = r_prod[50] ? 51'(-r_prod) : 51'(r_prod);

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[49]};
    assign rem_ge = rem_sh >= {1'b0, r_axle};
    assign rem_nx = rem_ge ? (rem_sh - {1'b0, r_axle}) : rem_sh;

    assign d34    = r_neg ? (34'd0 - r_quo) : r_quo;
    assign mid34  = {r_yaw, 18'd0} + d34;
    assign ang    = mid34[33:2];
    assign ang_q  = ang + 32'h2000_0000;
    assign quad   = ang_q[31:30];
    assign resid  = ang - {quad, 30'd0};

    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign atan_v = signed'({2'b00, ATAN_TURN32[r_i]});

    assign rnd     = {prod_mag[50:0], 5'd0} + HALF_25;
    assign rq      = r_t * RECIP_25;
    assign delta   = r_neg ? (32'd0 - {12'd0, r_q}) : {12'd0, r_q};
    assign yaw_sum = r_d34 + 34'h0_0001_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axle <= '0;
            r_px   <= '0;
            r_py   <= '0;
            r_yaw  <= '0;
            r_dcnt <= '0;
            r_i    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_axle <= i_cfg_data;
            end
            unique case (i_op) inside
                DP_LOAD: begin
                    r_is_clear <= i_in_data.op;
                    r_held     <= !i_in_data.op && (r_axle == 16'd0);
                    r_sum      <= 17'(i_in_data.left_travel) + 17'(i_in_data.right_travel);
                    r_diff     <= 17'(i_in_data.right_travel) - 17'(i_in_data.left_travel);
                end
                DP_CLEAR: begin
                    r_px  <= '0;
                    r_py  <= '0;
                    r_yaw <= '0;
                end
                DP_MULN, DP_MULC, DP_MULS: begin
                    r_prod <= mul_p;
                end
                DP_DIVINIT: begin
                    r_num  <= prod_mag[49:0] + {35'd0, r_axle[15:1]};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_neg  <= r_prod[50];
                    r_dcnt <= '0;
                end
                DP_DIVSTEP: begin
                    r_rem  <= rem_nx[15:0];
                    r_num  <= {r_num[48:0], 1'b0};
                    r_quo  <= {r_quo[32:0], rem_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                end
                DP_ANGLE: begin
                    r_d34  <= d34;
                    r_quad <= quad;
                    r_z    <= signed'({{2{resid[31]}}, resid});
                    r_x    <= CORDIC_GAIN;
                    r_y    <= '0;
                    r_i    <= '0;
                end
                DP_ROT: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_v;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_v;
                    end
                    r_i <= r_i + 1'b1;
                end
                DP_ROUND: begin
                    r_t   <= rnd[53:30];
                    r_neg <= r_prod[50];
                end
                DP_RECIP: begin
                    r_q <= rq[51:32];
                end
                DP_ADDX: begin
                    r_px <= r_px + signed'(delta);
                end
                DP_ADDY: begin
                    r_py  <= r_py + signed'(delta);
                    r_yaw <= r_yaw + yaw_sum[32:17];
                end
                DP_OUT: begin
                    r_out.pos_x   <= r_px;
                    r_out.pos_y   <= r_py;
                    r_out.heading <= signed'(r_yaw);
                    r_out.held    <= r_held;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.is_clear  = r_is_clear;
    assign o_sts.axle_zero = (r_axle == 16'd0);
    assign o_sts.div_last  = (r_dcnt == DIV_CNT_W'(DIV_BITS - 1));
    assign o_sts.rot_last  = (r_i == STEP_W'(NSTEP - 1));
    assign o_out_data      = r_out;

endmodule
`default_nettype wire

// ===== hdl/ddo_ctrl.sv =====
// odometry sequencer: steps the datapath through one word
`default_nettype none
module ddo_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    input  ddo_pkg::t_dp_sts i_sts,
    output ddo_pkg::t_dp_op  o_op
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_MULN,
        S_DIVINIT,
        S_DIV,
        S_ANGLE,
        S_ROT,
        S_MULC,
        S_RNDC,
        S_RECC,
        S_ADDX,
        S_MULS,
        S_RNDS,
        S_RECS,
        S_ADDY,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;
    logic   r_out_valid, n_out_valid;
    t_dp_op op;

    always_comb begin
        n_state     = r_state;
        n_in_stall  = r_in_stall;
        n_out_valid = r_out_valid && i_out_stall;
        op          = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op         = DP_LOAD;
                    n_in_stall = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_clear) begin
                    op      = DP_CLEAR;
                    n_state = S_OUT;
                end else if (i_sts.axle_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MULN;
                end
            end
            S_MULN:    begin op = DP_MULN;    n_state = S_DIVINIT; end
            S_DIVINIT: begin op = DP_DIVINIT; n_state = S_DIV;     end
            S_DIV: begin
                op = DP_DIVSTEP;
                if (i_sts.div_last) n_state = S_ANGLE;
            end
            S_ANGLE:   begin op = DP_ANGLE;   n_state = S_ROT;     end
            S_ROT: begin
                op = DP_ROT;
                if (i_sts.rot_last) n_state = S_MULC;
            end
            S_MULC: begin op = DP_MULC;  n_state = S_RNDC; end
            S_RNDC: begin op = DP_ROUND; n_state = S_RECC; end
            S_RECC: begin op = DP_RECIP; n_state = S_ADDX; end
            S_ADDX: begin op = DP_ADDX;  n_state = S_MULS; end
            S_MULS: begin op = DP_MULS;  n_state = S_RNDS; end
            S_RNDS: begin op = DP_ROUND; n_state = S_RECS; end
            S_RECS: begin op = DP_RECIP; n_state = S_ADDY; end
            S_ADDY: begin op = DP_ADDY;  n_state = S_OUT;  end
            S_OUT: begin
                // wait until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    op          = DP_OUT;
                    n_out_valid = 1'b1;
                    n_in_stall  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_op        = op;

endmodule
`default_nettype wire

// ===== hdl/differential_drive_odometry.sv =====
// top level of the differential drive odometry block
//
//   channel | direction | handshake               | word
//   in      | input     | i_in_valid/o_in_stall   | t_in_word
//   out     | output    | o_out_valid/i_out_stall | t_out_word
//   cfg     | input     | i_cfg_valid/o_cfg_ready | axle length, 16 bit
//
// one word at a time; an integrate word passes the 50-step divider and the cordic loop of
// min(CORDIC_STEPS, 24) steps between accept and result
// clear and held words skip both; the next word can be taken in the same cycle as the result
// reset is synchronous, active low, and leaves the pose and axle length at zero
// a stalled result stays in the output register while the next word is taken
`default_nettype none
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  ddo_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output ddo_pkg::t_out_word o_out_data,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire         [15:0] i_cfg_data
);
    import ddo_pkg::*;

    t_dp_op  op;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_op        (op)
    );

    ddo_dpath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== hdl/ddo_checker.sv =====
// port-level checks for the odometry block, bound to the top level
`default_nettype none
`include "differential_drive_odometry_macros.svh"
module ddo_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_stall,
    input wire                o_out_valid,
    input wire                i_out_stall,
    input ddo_pkg::t_out_word o_out_data
);
    import ddo_pkg::*;

    `DDO_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)
    `DDO_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `DDO_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `DDO_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);
`default_nettype wire

// ===== verif/differential_drive_odometry_checker.sv =====
// checker for the odometry block: predicts the pose and compares each result word
`default_nettype none
module differential_drive_odometry_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_stall,
    input  ddo_pkg::t_in_word  i_in_data,
    input  wire                i_out_valid,
    input  wire                i_out_stall,
    input  ddo_pkg::t_out_word i_out_data,
    input  wire                i_cfg_valid,
    input  wire                i_cfg_ready,
    input  wire         [15:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);
    import ddo_pkg::*;

    localparam int CORDIC_STEPS = 16;

    logic [15:0] axle;
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [15:0] pose_yaw;
    t_out_word   pose_q[$];

    // n / d rounded half away from zero
    function automatic longint div_half_away(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic void rotate_unit(logic [31:0] ang, output longint c,
                                        output longint s);
        logic [1:0]  quad;
        logic [31:0] r;
        longint      z;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        quad = 2'((ang + 32'h2000_0000) >> 30);
        r = ang - {quad, 30'd0};
        z = longint'(signed'(r));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(ATAN_TURN32[i]);
            end else begin
                x += ys; y -= xs; z += longint'(ATAN_TURN32[i]);
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic t_out_word advance_pose(t_in_word w);
        t_out_word   res;
        longint      lt;
        longint      rt;
        longint      turn;
        longint      c;
        longint      s;
        longint      sum;
        logic [33:0] mid;
        logic [63:0] yaw_step;
        res = '0;
        if (w.op) begin
            pose_x = 0; pose_y = 0; pose_yaw = 0;
        end else if (axle == 0) begin
            res.held = 1'b1;
        end else begin
            lt = longint'(w.left_travel);
            rt = longint'(w.right_travel);
            turn = div_half_away((rt - lt) * 1367130551, longint'(axle));
            mid = 34'({pose_yaw, 18'd0}) + 34'(turn);
            rotate_unit(mid[33:2], c, s);
            sum = lt + rt;
            pose_x += 32'(div_half_away(sum * c * 32, 25 * 64'd1073741824));
            pose_y += 32'(div_half_away(sum * s * 32, 25 * 64'd1073741824));
            yaw_step = 64'(turn + 65536) >> 17;
            pose_yaw += yaw_step[15:0];
        end
        res.pos_x = pose_x;
        res.pos_y = pose_y;
        res.heading = pose_yaw;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            axle <= '0;
            pose_x = 0; pose_y = 0; pose_yaw = 0;
            pose_q.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (pose_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pose_q.pop_front();
                    if (i_out_data !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_out_data.pos_x !== want.pos_x)
                            $error("pos_x expected %0d got %0d", want.pos_x, i_out_data.pos_x);
                        if (i_out_data.pos_y !== want.pos_y)
                            $error("pos_y expected %0d got %0d", want.pos_y, i_out_data.pos_y);
                        if (i_out_data.heading !== want.heading)
                            $error("heading expected %0d got %0d", want.heading,
                                   i_out_data.heading);
                        if (i_out_data.held !== want.held)
                            $error("held expected %0d got %0d", want.held, i_out_data.held);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pose_q = {pose_q, advance_pose(i_in_data)};
            if (i_cfg_valid && i_cfg_ready)
                axle <= i_cfg_data;
        end
    end

    assign o_pending = pose_q.size();
endmodule
`default_nettype wire

// ===== verif/tb_differential_drive_odometry.sv =====
// testbench top for the odometry block: stimulus, stall patterns and verdict
`default_nettype none
module tb_differential_drive_odometry;
    import ddo_pkg::*;

    localparam int WATCHDOG = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [15:0] cfg_data = '0;
    int        fail_count;
    int        pending;
    int        results_seen;
    int        idle_cycles;
    int        words_sent;
    bit        hold_off = 1'b0;
    bit        hold_done = 1'b0;

    always #6 clk = ~clk;

    differential_drive_odometry uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    differential_drive_odometry_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    // receiver stalls in phases; one long hold-off lets the block back up
    always @(posedge clk) begin
        if (hold_off)
            out_stall <= 1'b1;
        else case ((results_seen / 200) % 3)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    initial begin
        repeat (300) @(posedge clk);
        wait (words_sent > 700);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        hold_done = 1'b1;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired with %0d words outstanding", pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [15:0] pick_travel();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom());
            3: return 16'($urandom());
            default: return 16'(signed'(16'($urandom_range(0, 1200))) - 16'sd600);
        endcase
    endfunction

    // offers one word and holds it until taken
    task automatic send_word(logic op, logic [15:0] lt, logic [15:0] rt);
        in_valid <= 1'b1;
        in_data <= '{op: op, left_travel: lt, right_travel: rt};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    task automatic set_axle(logic [15:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] axles[6];
        int burst;
        axles = '{16'd0, 16'd1, 16'hffff, 16'd4096, 16'd12800, 16'd30};
        words_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero axle holds the pose, clear works regardless
        send_word(1'b0, 16'd100, 16'd200);
        send_word(1'b1, 16'h7fff, 16'h8000);
        set_axle(16'd1);
        send_word(1'b0, 16'h8000, 16'h7fff);
        send_word(1'b0, 16'h7fff, 16'h8000);
        send_word(1'b0, 16'h8000, 16'h8000);
        send_word(1'b0, 16'h7fff, 16'h7fff);
        send_word(1'b1, 16'd0, 16'd0);
        set_axle(16'hffff);
        send_word(1'b0, 16'h7fff, 16'h7fff);
        send_word(1'b0, 16'h8000, 16'h7fff);
        send_word(1'b0, 16'hffff, 16'h0001);
        send_word(1'b0, 16'd0, 16'd0);
        set_axle(16'd3200);
        for (int k = 0; k < 8; k++) send_word(1'b0, 16'd2000, 16'd2600);
        send_word(1'b1, 16'hffff, 16'hffff);

        for (int phase = 0; phase < 8; phase++) begin
            set_axle(phase == 0 ? axles[0] : (phase < 6 ? axles[phase]
                                                        : 16'($urandom())));
            for (int n = 0; n < 200; ) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 3) == 0) burst = 0;
                for (int b = 0; b < burst && n < 200; b++, n++)
                    send_word(($urandom_range(0, 40) == 0), pick_travel(), pick_travel());
                if (burst == 0 || $urandom_range(0, 1) == 0) gap();
            end
        end
        in_valid <= 1'b0;

        wait (hold_done);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("sent %0d words over eight axle settings incl. zero, 1 and 65535,", words_sent);
        $display("with clears, extreme travels and a long output hold-off");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
